FILE: hw/rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PhaseW  = 5;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 16;

  localparam logic [LimitW-1:0] LimitReset = 16'd40000;
  localparam logic [LimitW-1:0] CountMax   = 16'hFFFF;

  // Phase landmarks of the write and read sequences
  localparam logic [PhaseW-1:0] PhWrAck   = 5'd16;
  localparam logic [PhaseW-1:0] PhRdStr   = 5'd1;
  localparam logic [PhaseW-1:0] PhRdLast  = 5'd17;
  localparam logic [PhaseW-1:0] PhRdAck   = 5'd18;
  localparam logic [PhaseW-1:0] PhLast    = 5'd19;

  typedef enum logic [FuncW-1:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_RDACK = 3'd3,
    CMD_RDNAK = 3'd4,
    CMD_STOP  = 3'd5
  } cmd_t;

  // One input item as held in the input register
  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [ByteW-1:0] wr_byte;
    logic             scl_in;
    logic             sda_in;
  } item_t;

  // One result item from the engine
  typedef struct packed {
    logic             timed_out;
    logic             ack_fail;
    logic [ByteW-1:0] rd_byte;
    logic             done_res;
    logic             busy_res;
    logic             sda_release;
    logic             scl_release;
  } result_t;

endpackage

FILE: hw/rtl/i2cm_apb.sv
// ----------------------------------------------------------------------------
// i2cm_apb
// APB register slave holding the clock-stretch limit.
// ----------------------------------------------------------------------------
module i2cm_apb (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [i2cm_pkg::LimitW-1:0] stretch_limit
);
  import i2cm_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && !paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      stretch_limit <= LimitReset;
    end else if (wr_en) begin
      stretch_limit <= pwdata[LimitW-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {{(32-LimitW){1'b0}}, stretch_limit};

endmodule

FILE: hw/rtl/i2cm_engine.sv
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer state and the per-tick step logic: one item in, one result out.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  i2cm_pkg::item_t             item,
  input  logic [i2cm_pkg::LimitW-1:0] stretch_limit,
  output i2cm_pkg::result_t           result
);
  import i2cm_pkg::*;

  cmd_t              cmd, cmd_next;
  logic [PhaseW-1:0] phase, phase_next;
  logic [ByteW-1:0]  shift, shift_next;
  logic [ByteW-1:0]  rcv, rcv_next;
  logic [LimitW-1:0] scount, scount_next;
  logic              scl_r, scl_r_next;
  logic              sda_r, sda_r_next;
  logic              ackerr, ackerr_next;
  logic              tmo, tmo_next;
  logic              done;

  always_comb begin
    logic              start;
    logic              hold;
    logic              nack;
    logic [LimitW-1:0] lim;
    logic [ByteW-1:0]  shifted;

    start   = (cmd == CMD_IDLE) && (item.func >= CMD_START) && (item.func <= CMD_STOP);
    cmd_next    = start ? cmd_t'(item.func) : cmd;
    phase_next  = start ? '0 : phase;
    shift_next  = shift;
    scount_next = scount;
    ackerr_next = ackerr;
    tmo_next    = tmo;
    rcv_next    = rcv;
    scl_r_next  = scl_r;
    sda_r_next  = sda_r;
    done    = 1'b0;
    hold    = 1'b0;
    nack    = (cmd_next == CMD_RDNAK);
    lim     = (stretch_limit == '0) ? {{(LimitW-1){1'b0}}, 1'b1} : stretch_limit;
    shifted = {shift[ByteW-2:0], item.sda_in};

    if (start && cmd_next == CMD_WRITE) begin
      shift_next  = item.wr_byte;
      ackerr_next = 1'b0;
    end else if (start && (cmd_next == CMD_RDACK || cmd_next == CMD_RDNAK)) begin
      shift_next  = '0;
      scount_next = '0;
      tmo_next    = 1'b0;
    end

    unique case (cmd_next)
      CMD_START: begin
        if (phase_next == 5'd0) begin
          scl_r_next = 1'b1; sda_r_next = 1'b1;
        end else if (phase_next == 5'd1) begin
          scl_r_next = 1'b1; sda_r_next = 1'b0;
        end else begin
          scl_r_next = 1'b0; sda_r_next = 1'b0; done = 1'b1;
        end
      end
      CMD_STOP: begin
        scl_r_next = 1'b1;
        if (phase_next == 5'd0) begin
          sda_r_next = 1'b0;
        end else begin
          sda_r_next = 1'b1; done = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (phase_next < PhWrAck) begin
          scl_r_next = !phase_next[0];
          sda_r_next = shift_next[ByteW-1];
          if (phase_next[0]) begin
            shift_next = {shift_next[ByteW-2:0], 1'b0};
          end
        end else if (phase_next == PhWrAck) begin
          scl_r_next = 1'b1; sda_r_next = 1'b1;
        end else begin
          ackerr_next = item.sda_in;
          scl_r_next  = 1'b0; sda_r_next = 1'b1; done = 1'b1;
        end
      end
      CMD_RDACK, CMD_RDNAK: begin
        if (phase_next == 5'd0) begin
          scl_r_next = 1'b1; sda_r_next = 1'b1;
        end else if (phase_next == PhRdStr) begin
          scl_r_next = 1'b1; sda_r_next = 1'b1;
          if (!item.scl_in) begin
            // Count one stretched tick; give up once the limit is reached
            scount_next = (scount_next == CountMax) ? CountMax : scount_next + 1'b1;
            if (scount_next >= lim) begin
              tmo_next = 1'b1;
              done     = 1'b1;
            end else begin
              hold = 1'b1;
            end
          end
        end else if (phase_next <= PhRdLast) begin
          if (!phase_next[0]) begin
            scl_r_next = 1'b1; sda_r_next = 1'b1;
          end else begin
            shift_next = shifted;
            scl_r_next = 1'b0; sda_r_next = 1'b1;
            if (phase_next == PhRdLast) begin
              rcv_next = shifted;
            end
          end
        end else if (phase_next == PhRdAck) begin
          scl_r_next = 1'b1; sda_r_next = nack;
        end else begin
          scl_r_next = 1'b0; sda_r_next = nack; done = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (done) begin
      cmd_next   = CMD_IDLE;
      phase_next = '0;
    end else if (cmd_next != CMD_IDLE && !hold) begin
      phase_next = phase_next + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd    <= CMD_IDLE;
      phase  <= '0;
      shift  <= '0;
      rcv    <= '0;
      scount <= '0;
      scl_r  <= 1'b1;
      sda_r  <= 1'b1;
      ackerr <= 1'b0;
      tmo    <= 1'b0;
    end else if (step) begin
      cmd    <= cmd_next;
      phase  <= phase_next;
      shift  <= shift_next;
      rcv    <= rcv_next;
      scount <= scount_next;
      scl_r  <= scl_r_next;
      sda_r  <= sda_r_next;
      ackerr <= ackerr_next;
      tmo    <= tmo_next;
    end
  end

  always_comb begin
    result.scl_release = scl_r_next;
    result.sda_release = sda_r_next;
    result.busy_res    = (cmd_next != CMD_IDLE);
    result.done_res    = done;
    result.rd_byte     = rcv_next;
    result.ack_fail    = ackerr_next;
    result.timed_out   = tmo_next;
  end

  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_IDLE) |-> (phase == '0))
    else $error("idle engine with nonzero phase");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= PhLast)
    else $error("phase beyond last read phase");

  a_timeout_release: assert property (@(posedge clk) disable iff (rst)
    (step && tmo_next && !tmo) |=> (scl_r && sda_r && cmd == CMD_IDLE))
    else $error("read timeout did not release both lines");

endmodule

FILE: hw/rtl/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Open-drain I2C master sequencer stepped by half-bit timing ticks.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake         Contents
// s_        in   tvalid/tready     one tick: func, wr_byte, sampled scl/sda
// m_        out  tvalid/tready     one result: line drive and status
// apb       in   psel/penable      stretch_limit at byte address 0
//
// Flow: one item per clock while the result register is free or drained; an
//   item waits in the input register and its result loads into the output register on the engine step.
// The whole step for an item is one pass of the engine logic, between the
//   input register and the result register.
// Reset: synchronous, clears engine state to idle with both lines released;
//   stretch_limit returns to 40000. No clearing pass.
// Stalls: a held result blocks the engine step; the input register still
//   takes a new item while it is empty.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] wr_byte, [8] scl_in, [9] sda_in, [15:10] zero
  input  logic [2:0]  s_tuser,   // [2:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] scl_release, [1] sda_release, [2] busy_res,
                                 // [3] done_res, [11:4] rd_byte, [12] ack_fail,
                                 // [13] timed_out, [15:14] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import i2cm_pkg::*;

  logic              in_v;
  item_t             in_item;
  logic              adv;
  logic              step;
  result_t           res;
  result_t           out_res;
  logic [LimitW-1:0] stretch_limit;

  // Advance the engine whenever the result register is free or being drained
  assign adv      = !m_tvalid || m_tready;
  assign step     = in_v && adv;
  assign s_tready = !in_v || adv;

  // Input register: hold the tick until the engine can step on it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tready) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.func    <= s_tuser;
      in_item.wr_byte <= s_tdata[7:0];
      in_item.scl_in  <= s_tdata[8];
      in_item.sda_in  <= s_tdata[9];
    end
  end

  i2cm_apb u_apb (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .stretch_limit (stretch_limit)
  );

  i2cm_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .item          (in_item),
    .stretch_limit (stretch_limit),
    .result        (res)
  );

  // Result register: load on each step, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.timed_out, out_res.ack_fail, out_res.rd_byte,
                    out_res.done_res, out_res.busy_res, out_res.sda_release,
                    out_res.scl_release};

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |-> !m_tdata[2])
    else $error("result marks done while still busy");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty result register");

  a_stalled_hold: assert property (@(posedge clk) disable iff (rst)
    (in_v && !adv) |=> in_v)
    else $error("pending tick dropped during output stall");

endmodule
